### hdl/tds_pkg.sv
package tds_pkg;

  localparam int SET_DEPTH  = 256;
  localparam int IDX_W      = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int LEN_W      = $clog2(SET_DEPTH + 1);
  localparam int OPC_W      = 2;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [OPC_W-1:0] OP_DATA   = 2'd0;
  localparam logic [OPC_W-1:0] OP_LOAD_A = 2'd1;
  localparam logic [OPC_W-1:0] OP_LOAD_B = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DELETE_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SET_A_LENGTH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SET_B_LENGTH   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MOD,
    ST_BREAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [IDX_W-1:0] dividend;
    logic [LEN_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] rem;
  } mod_rsp_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [CFG_DATA_W-1:0] v);
    logic [LEN_W-1:0] res;
    if (32'(v) > 32'(SET_DEPTH)) begin
      res = LEN_W'(SET_DEPTH);
    end else begin
      res = LEN_W'(v);
    end
    return res;
  endfunction

endpackage

### hdl/tds_if.sv
interface tds_in_if;
  logic                       valid;
  logic                       ready;
  logic [tds_pkg::OPC_W-1:0]  opcode;
  logic [7:0]                 entry_index;
  logic [tds_pkg::BYTE_W-1:0] byte_value;
  logic                       first_of_string;

  modport source (output valid, output opcode, output entry_index, output byte_value,
                  output first_of_string, input ready);
  modport sink (input valid, input opcode, input entry_index, input byte_value,
                input first_of_string, output ready);
endinterface

interface tds_out_if;
  logic                       valid;
  logic                       ready;
  logic [tds_pkg::BYTE_W-1:0] out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink (input valid, input out_byte, output ready);
endinterface

interface tds_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tds_pkg::CFG_IDX_W-1:0]  index;
  logic [tds_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/tds_ram.sv
module tds_ram #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/tds_mod.sv
module tds_mod (
  input  logic              clk,
  input  logic              rst_n,
  input  tds_pkg::mod_req_t req,
  output tds_pkg::mod_rsp_t rsp
);
  import tds_pkg::*;

  localparam int CNT_W = $clog2(IDX_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] dvd_r, dvd_nxt;
  logic [LEN_W-1:0] div_r, div_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [LEN_W:0]   trial;

  // Restoring division, one dividend bit per cycle, keeping only the remainder.
  always_comb begin
    trial    = {rem_r, dvd_r[IDX_W-1]};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(IDX_W);
      dvd_nxt  = req.dividend;
      div_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = LEN_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = LEN_W'(trial);
      end
      dvd_nxt = dvd_r << 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r[IDX_W-1:0];

endmodule

### hdl/char_translate_delete_squeeze_top.sv
// Load and ignored beats keep the block idle, so from idle they stream at one beat per cycle.
// A data byte is looked up in the first N entries of set A, N being set A's length,
// which are read from its memory one entry per cycle until the first match.
// A translated byte also passes through the remainder unit and a set B read.
// The result sits in an output register, so the next beat is taken while it waits.
// Sync active-low reset clears control state, settings and squeeze history, not set memories.
module char_translate_delete_squeeze_top (
  input  logic clk,
  input  logic rst_n,
  tds_in_if.sink    in_ch,
  tds_out_if.source out_ch,
  tds_cfg_if.sink   cfg_ch
);
  import tds_pkg::*;

  state_t            state_r, state_nxt;
  logic              delete_mode_r;
  logic              squeeze_en_r;
  logic [LEN_W-1:0]  na_r;
  logic [LEN_W-1:0]  nb_r;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic              pend_r, pend_nxt;
  logic [IDX_W-1:0]  pidx_r, pidx_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic [BYTE_W-1:0] res_r, res_nxt;
  logic [BYTE_W-1:0] last_r, last_nxt;
  logic              have_last_r, have_last_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;

  logic              in_acc;
  logic              load_ok;
  logic [IDX_W-1:0]  load_addr;
  logic              we_a, we_b;
  logic [BYTE_W-1:0] a_rdata, b_rdata;
  logic              a_hit;
  logic              issue;
  logic              slot_free;
  logic              squeeze_drop;
  mod_req_t          mod_req;
  mod_rsp_t          mod_rsp;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign load_ok   = 32'(in_ch.entry_index) < 32'(SET_DEPTH);
  assign load_addr = IDX_W'(in_ch.entry_index);
  assign we_a      = in_acc && (in_ch.opcode == OP_LOAD_A) && load_ok;
  assign we_b      = in_acc && (in_ch.opcode == OP_LOAD_B) && load_ok;

  tds_ram #(.DEPTH(SET_DEPTH), .ADDR_W(IDX_W), .DATA_W(BYTE_W)) u_set_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (load_addr),
    .wdata (in_ch.byte_value),
    .raddr (cnt_r[IDX_W-1:0]),
    .rdata (a_rdata)
  );

  tds_ram #(.DEPTH(SET_DEPTH), .ADDR_W(IDX_W), .DATA_W(BYTE_W)) u_set_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (load_addr),
    .wdata (in_ch.byte_value),
    .raddr (mod_rsp.rem),
    .rdata (b_rdata)
  );

  tds_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  assign a_hit        = pend_r && (a_rdata == byte_r);
  assign issue        = cnt_r < na_r;
  assign slot_free    = !out_valid_r || out_ch.ready;
  assign squeeze_drop = squeeze_en_r && have_last_r && (res_r == last_r);

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    pend_nxt         = pend_r;
    pidx_nxt         = pidx_r;
    byte_nxt         = byte_r;
    res_nxt          = res_r;
    last_nxt         = last_r;
    have_last_nxt    = have_last_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    out_byte_nxt     = out_byte_r;
    mod_req.start    = 1'b0;
    mod_req.dividend = pidx_r;
    mod_req.divisor  = nb_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_ch.opcode == OP_DATA)) begin
          byte_nxt = in_ch.byte_value;
          res_nxt  = in_ch.byte_value;
          cnt_nxt  = '0;
          pend_nxt = 1'b0;
          if (in_ch.first_of_string) begin
            have_last_nxt = 1'b0;
          end
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        pend_nxt = issue;
        if (issue) begin
          cnt_nxt  = cnt_r + 1'b1;
          pidx_nxt = cnt_r[IDX_W-1:0];
        end
        if (a_hit) begin
          pend_nxt = 1'b0;
          if (delete_mode_r) begin
            state_nxt = ST_IDLE;
          end else if (nb_r == '0) begin
            state_nxt = ST_EMIT;
          end else begin
            mod_req.start = 1'b1;
            state_nxt     = ST_MOD;
          end
        end else if (!issue) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_MOD: begin
        if (mod_rsp.done) begin
          state_nxt = ST_BREAD;
        end
      end
      ST_BREAD: begin
        res_nxt   = b_rdata;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (squeeze_drop) begin
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = res_r;
          last_nxt      = res_r;
          have_last_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      last_r      <= '0;
      have_last_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      last_r      <= last_nxt;
      have_last_r <= have_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r     <= pidx_nxt;
    byte_r     <= byte_nxt;
    res_r      <= res_nxt;
    out_byte_r <= out_byte_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delete_mode_r <= 1'b0;
      squeeze_en_r  <= 1'b0;
      na_r          <= '0;
      nb_r          <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_DELETE_MODE:    delete_mode_r <= cfg_ch.data[0];
        REG_SQUEEZE_ENABLE: squeeze_en_r  <= cfg_ch.data[0];
        REG_SET_A_LENGTH:   na_r          <= clamp_len(cfg_ch.data);
        REG_SET_B_LENGTH:   nb_r          <= clamp_len(cfg_ch.data);
        default: begin
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_data_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_ch.opcode == OP_DATA)) |=> (state_r == ST_SCAN))
    else $error("data beat did not start a set A scan");

  a_mod_done_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
    mod_rsp.done |-> (state_r == ST_MOD))
    else $error("remainder finished outside its wait state");

  a_emit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EMIT) && !squeeze_drop && slot_free) |=>
      (out_valid_r && (out_byte_r == $past(res_r))))
    else $error("result not placed in the output register");
`endif

endmodule

### test/char_translate_delete_squeeze_top_test.sv
module char_translate_delete_squeeze_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tds_pkg::*;

  localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = SET_DEPTH + 40;
  localparam int DRAIN_LIMIT   = 50000;
  localparam int HOLD_CYCLES   = 400;
  localparam int REPORT_LIMIT  = 10;

  logic clk = 1'b0;
  logic rst_n;

  tds_in_if  in_ch();
  tds_out_if out_ch();
  tds_cfg_if cfg_ch();

  char_translate_delete_squeeze_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [BYTE_W-1:0]     set_a_mem [SET_DEPTH];
  logic [BYTE_W-1:0]     set_b_mem [SET_DEPTH];
  bit                    a_loaded [SET_DEPTH];
  bit                    b_loaded [SET_DEPTH];
  logic [BYTE_W-1:0]     last_out_byte;
  bit                    last_out_valid;
  bit                    mode_delete;
  bit                    mode_squeeze;
  logic [CFG_DATA_W-1:0] len_a_reg;
  logic [CFG_DATA_W-1:0] len_b_reg;
  logic [BYTE_W-1:0]     pending_bytes [$];
  logic [BYTE_W-1:0]     prev_data_byte;

  int unsigned burst_left;
  int unsigned hold_requests;
  int unsigned data_beats;
  int unsigned load_beats;
  int unsigned ignored_beats;
  int unsigned bytes_checked;
  int unsigned cfg_writes;
  int unsigned error_count;

  function automatic int unsigned live_len(input logic [CFG_DATA_W-1:0] v);
    return (v > SET_DEPTH) ? SET_DEPTH : int'(v);
  endfunction

  function automatic void predict_beat(input logic [OPC_W-1:0] op, input logic [7:0] idx,
                                       input logic [BYTE_W-1:0] b, input logic first);
    int unsigned na;
    int unsigned nb;
    int unsigned pos;
    bit hit;
    logic [BYTE_W-1:0] r;
    if (op == OP_LOAD_A || op == OP_LOAD_B) begin
      if (idx < SET_DEPTH) begin
        if (op == OP_LOAD_A) begin
          set_a_mem[idx] = b;
          a_loaded[idx] = 1'b1;
        end else begin
          set_b_mem[idx] = b;
          b_loaded[idx] = 1'b1;
        end
      end
      return;
    end
    if (op != OP_DATA) return;
    if (first) last_out_valid = 1'b0;
    na = live_len(len_a_reg);
    nb = live_len(len_b_reg);
    hit = 1'b0;
    pos = 0;
    for (int i = 0; i < na; i++) begin
      if (set_a_mem[i] == b) begin
        hit = 1'b1;
        pos = i;
        break;
      end
    end
    r = b;
    if (mode_delete) begin
      if (hit) return;
    end else if (nb != 0 && hit) begin
      r = set_b_mem[pos % nb];
    end
    if (mode_squeeze && last_out_valid && r == last_out_byte) return;
    last_out_byte = r;
    last_out_valid = 1'b1;
    pending_bytes = {pending_bytes, r};
  endfunction

  function automatic logic [BYTE_W-1:0] set_value();
    return ($urandom_range(0, 3) == 0) ? BYTE_W'($urandom_range(0, 7)) : BYTE_W'($urandom);
  endfunction

  function automatic logic [7:0] load_index();
    return ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 31)) : 8'($urandom);
  endfunction

  function automatic logic [BYTE_W-1:0] pick_data_byte();
    int unsigned na;
    int unsigned sel;
    na = live_len(len_a_reg);
    sel = $urandom_range(0, 99);
    if (sel < 45 && na != 0) return set_a_mem[$urandom_range(0, na - 1)];
    if (sel < 65) return prev_data_byte;
    if (sel < 70) return 8'h00;
    if (sel < 75) return 8'hFF;
    return BYTE_W'($urandom);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_length();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 1;
      2, 3, 4, 5, 6: return CFG_DATA_W'($urandom_range(2, 16));
      7, 8: return CFG_DATA_W'($urandom_range(17, 48));
      default: return CFG_DATA_W'($urandom_range(200, 511));
    endcase
  endfunction

  // Called and returns right after a falling edge. Valid stays high between beats of a burst.
  task automatic send_beat(input logic [OPC_W-1:0] op, input logic [7:0] idx,
                           input logic [BYTE_W-1:0] val, input logic first);
    in_ch.opcode = op;
    in_ch.entry_index = idx;
    in_ch.byte_value = val;
    in_ch.first_of_string = first;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_beat(op, idx, val, first);
    if (op == OP_DATA) begin
      data_beats++;
      prev_data_byte = val;
    end else if (op == OP_LOAD_A || op == OP_LOAD_B) begin
      load_beats++;
    end else begin
      ignored_beats++;
    end
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 12);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] ri, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.index = ri;
    cfg_ch.data = val;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    case (ri)
      REG_DELETE_MODE:    mode_delete = val[0];
      REG_SQUEEZE_ENABLE: mode_squeeze = val[0];
      REG_SET_A_LENGTH:   len_a_reg = val;
      REG_SET_B_LENGTH:   len_b_reg = val;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_config(input bit del, input bit sq, input logic [CFG_DATA_W-1:0] la,
                            input logic [CFG_DATA_W-1:0] lb);
    write_reg(REG_DELETE_MODE, {CFG_DATA_W'($urandom) & ~CFG_DATA_W'(1)} | CFG_DATA_W'(del));
    write_reg(REG_SQUEEZE_ENABLE, {CFG_DATA_W'($urandom) & ~CFG_DATA_W'(1)} | CFG_DATA_W'(sq));
    write_reg(REG_SET_A_LENGTH, la);
    write_reg(REG_SET_B_LENGTH, lb);
  endtask

  // A deleted byte gives no result but may still be scanning, so wait out a full scan too.
  task automatic settle_block();
    int waited;
    in_ch.valid = 1'b0;
    waited = 0;
    while (pending_bytes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Every entry inside the set lengths is written before any data byte can read it.
  task automatic prepare_sets();
    int unsigned na;
    int unsigned nb;
    na = live_len(len_a_reg);
    nb = live_len(len_b_reg);
    for (int i = 0; i < na; i++) begin
      if (!a_loaded[i] || i < 32) send_beat(OP_LOAD_A, 8'(i), set_value(), 1'($urandom));
    end
    for (int i = 0; i < nb; i++) begin
      if (!b_loaded[i] || i < 32) send_beat(OP_LOAD_B, 8'(i), set_value(), 1'($urandom));
    end
  endtask

  task automatic random_beat();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 78) begin
      send_beat(OP_DATA, 8'($urandom), pick_data_byte(), $urandom_range(0, 6) == 0);
    end else if (sel < 86) begin
      send_beat(OP_LOAD_A, load_index(), set_value(), 1'($urandom));
    end else if (sel < 94) begin
      send_beat(OP_LOAD_B, load_index(), set_value(), 1'($urandom));
    end else begin
      send_beat(OP_UNUSED, 8'($urandom), BYTE_W'($urandom), 1'($urandom));
    end
  endtask

  task automatic test_translate_directed();
    settle_block();
    set_config(1'b0, 1'b0, 4, 3);
    send_beat(OP_LOAD_A, 8'd0, 8'h00, 1'b0);
    send_beat(OP_LOAD_A, 8'd1, 8'hFF, 1'b1);
    send_beat(OP_LOAD_A, 8'd2, 8'h41, 1'b0);
    send_beat(OP_LOAD_A, 8'd3, 8'h00, 1'b1);
    send_beat(OP_LOAD_B, 8'd0, 8'h7A, 1'b0);
    send_beat(OP_LOAD_B, 8'd1, 8'hFF, 1'b0);
    send_beat(OP_LOAD_B, 8'd2, 8'h00, 1'b1);
    send_beat(OP_LOAD_B, 8'hFF, 8'h5A, 1'b1);
    send_beat(OP_DATA, 8'h00, 8'h00, 1'b1);
    send_beat(OP_DATA, 8'hFF, 8'hFF, 1'b0);
    send_beat(OP_DATA, 8'h00, 8'h41, 1'b0);
    send_beat(OP_DATA, 8'h00, 8'h55, 1'b0);
    send_beat(OP_UNUSED, 8'hFF, 8'hFF, 1'b1);
    send_beat(OP_DATA, 8'h00, 8'h80, 1'b1);
  endtask

  task automatic test_empty_set_b();
    settle_block();
    write_reg(REG_SET_B_LENGTH, 0);
    send_beat(OP_DATA, 8'h00, 8'h00, 1'b0);
    send_beat(OP_DATA, 8'h00, 8'h41, 1'b0);
  endtask

  task automatic test_squeeze_directed();
    settle_block();
    write_reg(REG_SET_B_LENGTH, 3);
    write_reg(REG_SQUEEZE_ENABLE, 1);
    send_beat(OP_DATA, 8'h00, 8'h41, 1'b1);
    send_beat(OP_DATA, 8'h00, 8'h41, 1'b0);
    send_beat(OP_LOAD_A, 8'd3, 8'h00, 1'b1);
    send_beat(OP_DATA, 8'h00, 8'h41, 1'b0);
    send_beat(OP_DATA, 8'h00, 8'h41, 1'b1);
    send_beat(OP_DATA, 8'h00, 8'h00, 1'b0);
    send_beat(OP_DATA, 8'h00, 8'h55, 1'b0);
    send_beat(OP_DATA, 8'h00, 8'h55, 1'b0);
  endtask

  task automatic test_delete_directed();
    settle_block();
    write_reg(REG_DELETE_MODE, 1);
    send_beat(OP_DATA, 8'h00, 8'h41, 1'b0);
    send_beat(OP_DATA, 8'h00, 8'h33, 1'b0);
    send_beat(OP_DATA, 8'h00, 8'h33, 1'b0);
    send_beat(OP_DATA, 8'h00, 8'h41, 1'b1);
    send_beat(OP_DATA, 8'h00, 8'h33, 1'b0);
    settle_block();
    write_reg(REG_SQUEEZE_ENABLE, 0);
    send_beat(OP_DATA, 8'h00, 8'h66, 1'b0);
    send_beat(OP_DATA, 8'h00, 8'h66, 1'b0);
    settle_block();
    write_reg(REG_SQUEEZE_ENABLE, 1);
    send_beat(OP_DATA, 8'h00, 8'h66, 1'b0);
  endtask

  task automatic test_full_sets();
    settle_block();
    for (int i = 0; i < SET_DEPTH; i++) send_beat(OP_LOAD_A, 8'(i), set_value(), 1'($urandom));
    for (int i = 0; i < SET_DEPTH; i++) send_beat(OP_LOAD_B, 8'(i), set_value(), 1'($urandom));
    settle_block();
    set_config(1'b0, 1'b1, 511, 257);
    repeat (20) send_beat(OP_DATA, 8'($urandom), pick_data_byte(), $urandom_range(0, 6) == 0);
    settle_block();
    set_config(1'b1, 1'b0, 256, 256);
    repeat (20) send_beat(OP_DATA, 8'($urandom), pick_data_byte(), $urandom_range(0, 6) == 0);
  endtask

  task automatic test_random_mix();
    repeat (3) begin
      settle_block();
      set_config(1'($urandom), 1'($urandom), pick_length(), pick_length());
      prepare_sets();
      repeat (20) random_beat();
    end
  endtask

  // The receiver stops for a long stretch while data keeps coming, so the input backs up.
  task automatic test_backpressure();
    settle_block();
    set_config(1'b0, 1'b0, 3, 2);
    prepare_sets();
    hold_requests++;
    repeat (40) send_beat(OP_DATA, 8'($urandom), pick_data_byte(), 1'b0);
  endtask

  initial begin : result_stall
    int unsigned mode;
    int unsigned span;
    int unsigned period;
    int unsigned cyc;
    int unsigned hold_left;
    int unsigned holds_served;
    out_ch.ready = 1'b0;
    mode = 0;
    span = 0;
    period = 1;
    cyc = 0;
    hold_left = 0;
    holds_served = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 2);
          span = $urandom_range(20, 150);
          period = $urandom_range(2, 6);
        end
        span--;
        case (mode)
          0: out_ch.ready = 1'b1;
          1: out_ch.ready = ((cyc % period) == 0);
          default: out_ch.ready = 1'($urandom);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_results
    logic [BYTE_W-1:0] want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_bytes.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
          $display("unexpected result beat: out_byte=%02h", out_ch.out_byte);
        end
      end else begin
        want = pending_bytes.pop_front();
        bytes_checked++;
        if (out_ch.out_byte !== want) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("out_byte mismatch: expected %02h, got %02h", want, out_ch.out_byte);
          end
        end
      end
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("[char_translate_delete_squeeze_top] ERROR");
    $finish;
  end

  initial begin : run_tests
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_DATA;
    in_ch.entry_index = '0;
    in_ch.byte_value = '0;
    in_ch.first_of_string = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_DELETE_MODE;
    cfg_ch.data = '0;
    last_out_byte = '0;
    last_out_valid = 1'b0;
    mode_delete = 1'b0;
    mode_squeeze = 1'b0;
    len_a_reg = '0;
    len_b_reg = '0;
    prev_data_byte = '0;
    burst_left = 5;
    hold_requests = 0;
    data_beats = 0;
    load_beats = 0;
    ignored_beats = 0;
    bytes_checked = 0;
    cfg_writes = 0;
    error_count = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_translate_directed();
    test_empty_set_b();
    test_squeeze_directed();
    test_delete_directed();
    test_full_sets();
    test_random_mix();
    test_backpressure();

    settle_block();
    if (pending_bytes.size() != 0) begin
      error_count += pending_bytes.size();
      $display("%0d expected result bytes never arrived", pending_bytes.size());
    end
    $display("sent %0d beats (%0d data, %0d set loads, %0d unused opcode), checked %0d bytes",
             data_beats + load_beats + ignored_beats, data_beats, load_beats, ignored_beats,
             bytes_checked);
    $display("%0d register writes over translate/delete, squeeze and set lengths 0 to 511",
             cfg_writes);
    if (error_count == 0) begin
      $display("[char_translate_delete_squeeze_top] OK");
    end else begin
      $display("[char_translate_delete_squeeze_top] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
hdl/tds_pkg.sv
hdl/tds_if.sv
hdl/tds_ram.sv
hdl/tds_mod.sv
hdl/char_translate_delete_squeeze_top.sv
test/char_translate_delete_squeeze_top_test.sv
